// ===== rtl/core/udp_ipv4_header_builder_defines.svh =====
// Assertion macros used by the checker file.
`ifndef UDP_IPV4_HEADER_BUILDER_DEFINES_SVH
`define UDP_IPV4_HEADER_BUILDER_DEFINES_SVH

// Checked on every clock edge outside reset.
`define UDP_HB_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("udp header builder check failed");

// Checked on every clock edge, reset included.
`define UDP_HB_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("udp header builder reset check failed");

`endif

// ===== rtl/core/udp_hb_pkg.sv =====
package udp_hb_pkg;

  localparam int unsigned MAX_PAYLOAD = 1472;
  localparam int unsigned LEN_W       = 11;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [15:0]      IDENT_RESET    = 16'h0011;
  localparam logic [7:0]       PROTO_UDP      = 8'h11;
  localparam logic [7:0]       IP_TTL         = 8'd64;
  localparam logic [15:0]      IP_VER_IHL_TOS = 16'h4500;
  localparam logic [LEN_W-1:0] IPV4_HDR_LEN   = LEN_W'(20);
  localparam logic [LEN_W-1:0] UDP_HDR_LEN    = LEN_W'(8);
  localparam logic [LEN_W-1:0] MAX_COUNT      = LEN_W'(MAX_PAYLOAD);
  localparam logic [LEN_W-1:0] MAX_UDP_LENGTH = LEN_W'(MAX_PAYLOAD + 8);

  typedef struct packed {
    logic [47:0]      remote_mac;
    logic [47:0]      local_mac;
    logic [31:0]      remote_ip;
    logic [31:0]      local_ip;
    logic [15:0]      peer_udp_port;
    logic [15:0]      own_udp_port;
    logic [LEN_W-1:0] byte_count;
    logic [15:0]      payload_sum;
    logic [15:0]      ident;
    logic             too_long;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [15:0] oc_add(logic [15:0] a, logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

// ===== rtl/core/udp_hb_if.sv =====
interface udp_hb_byte_if;
  logic        valid;
  logic        ready;
  logic [7:0]  payload_byte;
  logic        last_byte;
  logic [47:0] remote_mac;
  logic [47:0] local_mac;
  logic [31:0] remote_ip;
  logic [31:0] local_ip;
  logic [15:0] peer_udp_port;
  logic [15:0] own_udp_port;

  modport source (
    output valid, payload_byte, last_byte, remote_mac, local_mac,
           remote_ip, local_ip, peer_udp_port, own_udp_port,
    input  ready
  );
  modport sink (
    input  valid, payload_byte, last_byte, remote_mac, local_mac,
           remote_ip, local_ip, peer_udp_port, own_udp_port,
    output ready
  );
endinterface

interface udp_hb_header_if;
  logic                          valid;
  logic                          ready;
  logic [47:0]                   dest_mac;
  logic [47:0]                   source_mac;
  logic [31:0]                   dest_ip;
  logic [31:0]                   source_ip;
  logic [15:0]                   dest_port;
  logic [15:0]                   source_port;
  logic [udp_hb_pkg::LEN_W-1:0]  ip_total_length;
  logic [15:0]                   ip_ident;
  logic [15:0]                   ip_checksum;
  logic [udp_hb_pkg::LEN_W-1:0]  udp_length;
  logic [15:0]                   udp_checksum;
  logic                          overlength;

  modport source (
    output valid, dest_mac, source_mac, dest_ip, source_ip, dest_port,
           source_port, ip_total_length, ip_ident, ip_checksum, udp_length,
           udp_checksum, overlength,
    input  ready
  );
  modport sink (
    input  valid, dest_mac, source_mac, dest_ip, source_ip, dest_port,
           source_port, ip_total_length, ip_ident, ip_checksum, udp_length,
           udp_checksum, overlength,
    output ready
  );
endinterface

// ===== rtl/core/udp_hb_front.sv =====
module udp_hb_front (
  input  logic                  clk,
  input  logic                  rst,
  udp_hb_byte_if.sink           byte_stream,
  input  udp_hb_pkg::q_status_t q_status,
  output logic                  push,
  output udp_hb_pkg::job_t      job
);

  logic [15:0]                  ident;
  logic [15:0]                  payload_sum;
  logic [udp_hb_pkg::LEN_W-1:0] byte_count;
  logic [7:0]                   high_byte_hold;
  logic                         odd_phase;
  logic                         too_long;

  logic                         accept;
  logic                         take;
  logic                         add_en;
  logic [15:0]                  word;
  logic [15:0]                  payload_sum_next;
  logic [udp_hb_pkg::LEN_W-1:0] byte_count_next;
  logic [15:0]                  ident_next;

  assign byte_stream.ready = !q_status.full;
  assign accept            = byte_stream.valid && byte_stream.ready;
  assign take              = byte_count < udp_hb_pkg::MAX_COUNT;

  // An odd final byte, or a held byte when the tail was dropped, is padded low.
  always_comb begin
    add_en = 1'b0;
    word   = {high_byte_hold, byte_stream.payload_byte};
    if (take && odd_phase) begin
      add_en = 1'b1;
    end else if (take && byte_stream.last_byte) begin
      add_en = 1'b1;
      word   = {byte_stream.payload_byte, 8'h00};
    end else if (!take && odd_phase && byte_stream.last_byte) begin
      add_en = 1'b1;
      word   = {high_byte_hold, 8'h00};
    end
  end

  assign payload_sum_next = add_en ? udp_hb_pkg::oc_add(payload_sum, word) : payload_sum;
  assign byte_count_next  = take ? byte_count + udp_hb_pkg::LEN_W'(1) : byte_count;
  assign ident_next       = ident + 16'd1;

  assign push = accept && byte_stream.last_byte;

  always_comb begin
    job.remote_mac    = byte_stream.remote_mac;
    job.local_mac     = byte_stream.local_mac;
    job.remote_ip     = byte_stream.remote_ip;
    job.local_ip      = byte_stream.local_ip;
    job.peer_udp_port = byte_stream.peer_udp_port;
    job.own_udp_port  = byte_stream.own_udp_port;
    job.byte_count    = byte_count_next;
    job.payload_sum   = payload_sum_next;
    job.ident         = ident_next;
    job.too_long      = too_long || !take;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ident          <= udp_hb_pkg::IDENT_RESET;
      payload_sum    <= '0;
      byte_count     <= '0;
      high_byte_hold <= '0;
      odd_phase      <= 1'b0;
      too_long       <= 1'b0;
    end else if (accept) begin
      if (byte_stream.last_byte) begin
        ident          <= ident_next;
        payload_sum    <= '0;
        byte_count     <= '0;
        high_byte_hold <= '0;
        odd_phase      <= 1'b0;
        too_long       <= 1'b0;
      end else begin
        payload_sum <= payload_sum_next;
        byte_count  <= byte_count_next;
        if (take) begin
          if (!odd_phase) begin
            high_byte_hold <= byte_stream.payload_byte;
          end
          odd_phase <= !odd_phase;
        end else begin
          too_long <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/core/udp_hb_queue.sv =====
module udp_hb_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  udp_hb_pkg::job_t      push_job,
  input  logic                  pop,
  output udp_hb_pkg::job_t      head,
  output udp_hb_pkg::q_status_t status
);

  udp_hb_pkg::job_t               entries [udp_hb_pkg::QUEUE_DEPTH];
  logic [udp_hb_pkg::QPTR_W-1:0]  wr_ptr;
  logic [udp_hb_pkg::QPTR_W-1:0]  rd_ptr;
  logic [udp_hb_pkg::QPTR_W:0]    fill;

  assign status.full  = fill == (udp_hb_pkg::QPTR_W + 1)'(udp_hb_pkg::QUEUE_DEPTH);
  assign status.empty = fill == '0;
  assign head         = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + udp_hb_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + udp_hb_pkg::QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   fill <= fill + (udp_hb_pkg::QPTR_W + 1)'(1);
        2'b01:   fill <= fill - (udp_hb_pkg::QPTR_W + 1)'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== rtl/core/udp_hb_back.sv =====
module udp_hb_back (
  input  logic                  clk,
  input  logic                  rst,
  input  udp_hb_pkg::q_status_t q_status,
  input  udp_hb_pkg::job_t      head,
  output logic                  pop,
  udp_hb_header_if.source       header
);

  logic                         advance;

  logic                         s1_valid;
  udp_hb_pkg::job_t             s1_job;
  logic [17:0]                  s1_addr_sum;
  logic [udp_hb_pkg::LEN_W-1:0] s1_tot_len;
  logic [udp_hb_pkg::LEN_W-1:0] s1_udp_len;

  logic                         s2_valid;
  udp_hb_pkg::job_t             s2_job;
  logic [udp_hb_pkg::LEN_W-1:0] s2_tot_len;
  logic [udp_hb_pkg::LEN_W-1:0] s2_udp_len;
  logic [19:0]                  s2_ip_wide;
  logic [19:0]                  s2_udp_wide;

  // Both sums are known to be non-zero, so a wide sum folded twice equals
  // the end-around-carry chain.
  function automatic logic [15:0] fold_not(logic [19:0] w);
    logic [16:0] f1;
    logic [15:0] f2;
    f1 = {1'b0, w[15:0]} + {13'd0, w[19:16]};
    f2 = f1[15:0] + {15'd0, f1[16]};
    return ~f2;
  endfunction

  assign advance = !header.valid || header.ready;
  assign pop     = advance && !q_status.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      header.valid <= 1'b0;
    end else if (advance) begin
      s1_valid     <= pop;
      s2_valid     <= s1_valid;
      header.valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_job      <= head;
      s1_addr_sum <= {2'b0, head.local_ip[31:16]} + {2'b0, head.local_ip[15:0]}
                   + {2'b0, head.remote_ip[31:16]} + {2'b0, head.remote_ip[15:0]};
      s1_tot_len  <= head.byte_count + udp_hb_pkg::IPV4_HDR_LEN + udp_hb_pkg::UDP_HDR_LEN;
      s1_udp_len  <= head.byte_count + udp_hb_pkg::UDP_HDR_LEN;

      s2_job      <= s1_job;
      s2_tot_len  <= s1_tot_len;
      s2_udp_len  <= s1_udp_len;
      s2_ip_wide  <= {2'b0, s1_addr_sum}
                   + {4'b0, udp_hb_pkg::IP_VER_IHL_TOS}
                   + {4'b0, udp_hb_pkg::IP_TTL, udp_hb_pkg::PROTO_UDP}
                   + {9'b0, s1_tot_len}
                   + {4'b0, s1_job.ident};
      s2_udp_wide <= {2'b0, s1_addr_sum}
                   + {12'b0, udp_hb_pkg::PROTO_UDP}
                   + {8'b0, s1_udp_len, 1'b0}
                   + {4'b0, s1_job.payload_sum}
                   + {4'b0, s1_job.own_udp_port}
                   + {4'b0, s1_job.peer_udp_port};

      header.dest_mac        <= s2_job.remote_mac;
      header.source_mac      <= s2_job.local_mac;
      header.dest_ip         <= s2_job.remote_ip;
      header.source_ip       <= s2_job.local_ip;
      header.dest_port       <= s2_job.peer_udp_port;
      header.source_port     <= s2_job.own_udp_port;
      header.ip_total_length <= s2_tot_len;
      header.ip_ident        <= s2_job.ident;
      header.ip_checksum     <= fold_not(s2_ip_wide);
      header.udp_length      <= s2_udp_len;
      header.udp_checksum    <= fold_not(s2_udp_wide);
      header.overlength      <= s2_job.too_long;
    end
  end

endmodule

// ===== rtl/core/udp_ipv4_header_builder.sv =====
// Builds one Ethernet/IPv4/UDP reply header per packet. Payload bytes enter
// on byte_stream at one transfer per clock while ready is high; the transfer
// with last_byte set supplies the addresses and ports, and its job passes
// through the queue, a two-stage checksum pipeline and the output register.
// Up to four finished packets are held in a queue between the byte
// accumulator and the checksum pipeline, so byte_stream keeps running while
// header is stalled; ready drops only when that queue is full. Bytes beyond
// the maximum payload are dropped and reported through overlength.
module udp_ipv4_header_builder (
  input  logic            clk,
  input  logic            rst,
  udp_hb_byte_if.sink     byte_stream,
  udp_hb_header_if.source header
);

  udp_hb_pkg::q_status_t q_status;
  udp_hb_pkg::job_t      push_job;
  udp_hb_pkg::job_t      head;
  logic                  push;
  logic                  pop;

  udp_hb_front u_front (
    .clk         (clk),
    .rst         (rst),
    .byte_stream (byte_stream),
    .q_status    (q_status),
    .push        (push),
    .job         (push_job)
  );

  udp_hb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  udp_hb_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_status (q_status),
    .head     (head),
    .pop      (pop),
    .header   (header)
  );

endmodule

// ===== rtl/core/udp_hb_checker.sv =====
`include "udp_ipv4_header_builder_defines.svh"

module udp_hb_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         header_valid,
  input logic                         header_ready,
  input logic [udp_hb_pkg::LEN_W-1:0] ip_total_length,
  input logic [udp_hb_pkg::LEN_W-1:0] udp_length,
  input logic [15:0]                  udp_checksum,
  input logic                         overlength
);

  `UDP_HB_ASSERT_RST(a_idle_after_reset, rst |=> !header_valid)
  `UDP_HB_ASSERT(a_stall_holds, header_valid && !header_ready |=> header_valid && $stable(udp_checksum))
  `UDP_HB_ASSERT(a_length_relation, header_valid |-> ip_total_length == udp_length + udp_hb_pkg::IPV4_HDR_LEN)
  `UDP_HB_ASSERT(a_overlength_saturates, header_valid && overlength |-> udp_length == udp_hb_pkg::MAX_UDP_LENGTH)

endmodule

bind udp_ipv4_header_builder udp_hb_checker u_checker (
  .clk             (clk),
  .rst             (rst),
  .header_valid    (header.valid),
  .header_ready    (header.ready),
  .ip_total_length (header.ip_total_length),
  .udp_length      (header.udp_length),
  .udp_checksum    (header.udp_checksum),
  .overlength      (header.overlength)
);
